>>> design/dle_pkg.sv
// Shared constants, types and helper functions of the dilogarithm evaluator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package dle_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int INT_BITS_DEF  = 16;
    localparam int WORK_BITS     = 54;
    localparam int LOG_BITS      = 56;
    localparam int LOG_STEPS     = LOG_BITS;
    localparam int MUL_LAT       = 2;
    localparam int LOG_LAT       = 2 + 2 * LOG_STEPS + 1 + MUL_LAT;
    localparam int SER_TERMS     = 7;
    localparam int SER_LAT       = SER_TERMS * (MUL_LAT + 1);

    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

    typedef logic signed [63:0] work_t;

    typedef enum logic [6:0] {
        REG_NEG_BIG = 7'b0000001,
        REG_NEG     = 7'b0000010,
        REG_LOW     = 7'b0000100,
        REG_MID     = 7'b0001000,
        REG_ONE     = 7'b0010000,
        REG_HIGH    = 7'b0100000,
        REG_BIG     = 7'b1000000
    } region_t;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [5:0] msb;
    } log_tag_t;

    localparam work_t W_ONE = work_t'(64'd1 << WORK_BITS);

    function automatic logic [63:0] frac_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = n;
        for (int i = 0; i < WORK_BITS; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d)
            begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic work_t coef(input int idx);
        logic [63:0] q;
        q = '0;
        case (idx)
            0:       q = frac_div(64'd1, 64'd36);
            1:       q = frac_div(64'd1, 64'd3600);
            2:       q = frac_div(64'd1, 64'd211680);
            3:       q = frac_div(64'd1, 64'd30 * 64'd362880);
            4:       q = frac_div(64'd5, 64'd66 * 64'd39916800);
            5:       q = frac_div(64'd691, 64'd2730 * 64'd39916800 * 64'd156);
            6:       q = frac_div(64'd1, 64'd39916800 * 64'd28080);
            default: q = '0;
        endcase
        return (idx == 1 || idx == 3 || idx == 5) ? -work_t'(q) : work_t'(q);
    endfunction

    localparam work_t PI6 =
        W_ONE + work_t'(frac_div(64'd644934066848226, 64'd1000000000000000));

    function automatic logic [63:0] mag(input work_t a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    // Product with an exact power of two below one, truncated toward zero.
    function automatic work_t shr_mag(input work_t a, input int sh);
        logic [63:0] m;
        m = mag(a) >> sh;
        return a[63] ? -work_t'(m) : work_t'(m);
    endfunction

endpackage

`default_nettype wire

>>> design/dle_if.sv
// Handshake channels of the dilogarithm evaluator: argument and result words.
// Depends on dle_pkg for the default widths.
`default_nettype none

interface dle_x_if
    import dle_pkg::*;
#(
    parameter int WIDTH = INT_BITS_DEF + FRAC_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

interface dle_li2_if
    import dle_pkg::*;
#(
    parameter int WIDTH = INT_BITS_DEF + FRAC_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] li2_value;

    modport source (output valid, output li2_value, input ready);
    modport sink (input valid, input li2_value, output ready);
endinterface

`default_nettype wire

>>> design/dle_fmul.sv
// Two-stage sign-magnitude 64 x 64 multiplier from four 32 x 32 partial products.
// Depends on dle_pkg.
`default_nettype none

module dle_fmul
    import dle_pkg::*;
#(
    parameter int SHIFT = WORK_BITS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld,
    input  logic [63:0] a_mag,
    input  logic [63:0] b_mag,
    input  logic        neg,
    output logic        res_vld,
    output work_t       prod
);

    logic        vld1_reg;
    logic        neg1_reg;
    logic [63:0] ll_reg;
    logic [63:0] lh_reg;
    logic [63:0] hl_reg;
    logic [63:0] hh_reg;
    logic        vld2_reg;
    work_t       prod_reg;
    work_t       prod_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= neg;
            ll_reg   <= 64'(a_mag[31:0]) * 64'(b_mag[31:0]);
            lh_reg   <= 64'(a_mag[31:0]) * 64'(b_mag[63:32]);
            hl_reg   <= 64'(a_mag[63:32]) * 64'(b_mag[31:0]);
            hh_reg   <= 64'(a_mag[63:32]) * 64'(b_mag[63:32]);
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        logic [127:0] sum;
        logic [127:0] sh;
        logic [63:0]  r;
        sum = (128'(hh_reg) << 64) + (128'(lh_reg) << 32) + (128'(hl_reg) << 32)
            + 128'(ll_reg);
        sh  = sum >> SHIFT;
        r   = {1'b0, sh[62:0]};
        prod_next = neg1_reg ? -work_t'(r) : work_t'(r);
    end

    assign res_vld = vld2_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

>>> design/dle_sqstep.sv
// One bit of the base-two logarithm: square the mantissa over two stages and renormalise.
// Depends on dle_pkg.
`default_nettype none

module dle_sqstep
    import dle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  log_tag_t            tag_in,
    input  logic [62:0]         t_in,
    input  logic [LOG_BITS-1:0] frac_in,
    output log_tag_t            tag_out,
    output logic [62:0]         t_out,
    output logic [LOG_BITS-1:0] frac_out
);

    log_tag_t            tag_a_reg;
    logic [61:0]         hh_reg;
    logic [62:0]         hl_reg;
    logic [63:0]         ll_reg;
    logic [LOG_BITS-1:0] frac_a_reg;
    log_tag_t            tag_b_reg;
    logic [62:0]         t_b_reg;
    logic [LOG_BITS-1:0] frac_b_reg;
    logic [62:0]         t_next;
    logic [LOG_BITS-1:0] frac_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg     <= {31'd0, t_in[62:32]} * {31'd0, t_in[62:32]};
            hl_reg     <= {32'd0, t_in[62:32]} * {31'd0, t_in[31:0]};
            ll_reg     <= {32'd0, t_in[31:0]} * {32'd0, t_in[31:0]};
            frac_a_reg <= frac_in;
            t_b_reg    <= t_next;
            frac_b_reg <= frac_next;
        end
    end

    always_comb
    begin
        logic [127:0] sq_full;
        logic [63:0]  sq;
        sq_full = (128'(hh_reg) << 64) + (128'(hl_reg) << 33) + 128'(ll_reg);
        sq      = sq_full[125:62];
        t_next    = sq[63] ? sq[63:1] : sq[62:0];
        frac_next = {frac_a_reg[LOG_BITS-2:0], sq[63]};
    end

    assign tag_out  = tag_b_reg;
    assign t_out    = t_b_reg;
    assign frac_out = frac_b_reg;

endmodule

`default_nettype wire

>>> design/dle_log.sv
// Pipelined natural logarithm of m * 2^-K: normalise, square-and-compare, scale by ln 2.
// Depends on dle_pkg, dle_sqstep and dle_fmul.
`default_nettype none

module dle_log
    import dle_pkg::*;
#(
    parameter int MW = INT_BITS_DEF + FRAC_BITS_DEF + 1,
    parameter int K  = FRAC_BITS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld,
    input  logic [MW-1:0] m,
    output logic          res_vld,
    output work_t         lg
);

    log_tag_t            tag0_next;
    log_tag_t            tag1_reg;
    logic [MW-1:0]       m1_reg;
    log_tag_t            tag2_reg;
    logic [62:0]         t2_reg;
    log_tag_t            tag_ch  [LOG_STEPS+1];
    logic [62:0]         t_ch    [LOG_STEPS+1];
    logic [LOG_BITS-1:0] frac_ch [LOG_STEPS+1];
    logic                lv_reg;
    logic                ln_reg;
    logic [63:0]         lm_reg;
    logic                ln_next;
    logic [63:0]         lm_next;

    always_comb
    begin
        tag0_next.valid = vld;
        tag0_next.zero  = (m == '0);
        tag0_next.msb   = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (m[i])
            begin
                tag0_next.msb = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            lv_reg   <= 1'b0;
        end
        else if (en)
        begin
            tag1_reg <= tag0_next;
            tag2_reg <= tag1_reg;
            lv_reg   <= tag_ch[LOG_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m;
            t2_reg <= 63'(m1_reg) << (6'd62 - tag1_reg.msb);
            ln_reg <= ln_next;
            lm_reg <= lm_next;
        end
    end

    assign tag_ch[0]  = tag2_reg;
    assign t_ch[0]    = t2_reg;
    assign frac_ch[0] = '0;

    for (genvar i = 0; i < LOG_STEPS; i++)
    begin : g_step
        dle_sqstep u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .tag_in   (tag_ch[i]),
            .t_in     (t_ch[i]),
            .frac_in  (frac_ch[i]),
            .tag_out  (tag_ch[i+1]),
            .t_out    (t_ch[i+1]),
            .frac_out (frac_ch[i+1])
        );
    end

    always_comb
    begin
        log_tag_t tg;
        tg = tag_ch[LOG_STEPS];
        if (tg.zero)
        begin
            ln_next = 1'b0;
            lm_next = '0;
        end
        else if (int'(tg.msb) >= K)
        begin
            ln_next = 1'b0;
            lm_next = (64'(int'(tg.msb) - K) << LOG_BITS) | 64'(frac_ch[LOG_STEPS]);
        end
        else
        begin
            ln_next = 1'b1;
            lm_next = (64'(K - int'(tg.msb)) << LOG_BITS) - 64'(frac_ch[LOG_STEPS]);
        end
    end

    dle_fmul #(
        .SHIFT (64 + LOG_BITS - WORK_BITS)
    ) u_ln2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (lv_reg),
        .a_mag   (lm_reg),
        .b_mag   (LN2_Q64),
        .neg     (ln_reg),
        .res_vld (res_vld),
        .prod    (lg)
    );

endmodule

`default_nettype wire

>>> design/dle_series.sv
// Horner evaluation of the Bernoulli polynomial in z squared, three stages per term.
// Depends on dle_pkg and dle_fmul.
`default_nettype none

module dle_series
    import dle_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  vld,
    input  work_t z2,
    output logic  res_vld,
    output work_t poly
);

    logic  vld_ch [SER_TERMS+1];
    work_t acc_ch [SER_TERMS+1];
    work_t z2_ch  [SER_TERMS+1];

    assign vld_ch[0] = vld;
    assign acc_ch[0] = coef(SER_TERMS - 1);
    assign z2_ch[0]  = z2;

    for (genvar j = 0; j < SER_TERMS; j++)
    begin : g_term
        localparam work_t ADD_K = (j == SER_TERMS - 1) ? W_ONE : coef(SER_TERMS - 2 - j);

        logic  pv;
        work_t pr;
        work_t z2_d1_reg;
        work_t z2_d2_reg;
        logic  v_reg;
        work_t acc_reg;
        work_t z2_reg;

        dle_fmul u_mul (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld     (vld_ch[j]),
            .a_mag   (mag(acc_ch[j])),
            .b_mag   (mag(z2_ch[j])),
            .neg     (acc_ch[j][63] ^ z2_ch[j][63]),
            .res_vld (pv),
            .prod    (pr)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z2_d1_reg <= z2_ch[j];
                z2_d2_reg <= z2_d1_reg;
                z2_reg    <= z2_d2_reg;
                acc_reg   <= pr + ADD_K;
            end
        end

        assign vld_ch[j+1] = v_reg;
        assign acc_ch[j+1] = acc_reg;
        assign z2_ch[j+1]  = z2_reg;
    end

    assign res_vld = vld_ch[SER_TERMS];
    assign poly    = acc_ch[SER_TERMS];

endmodule

`default_nettype wire

>>> design/dilogarithm_evaluator.sv
// Top level of the dilogarithm evaluator: region decode, logarithms, series and reconstruction.
// Depends on dle_pkg, dle_if, dle_log, dle_series and dle_fmul.
//
// Use of the block:
// The argument channel arg carries one word per item: x_value, signed fixed point with
// FRAC_BITS fraction bits. The result channel res returns one word per argument,
// li2_value, the real part of Li2(x) in the same format, rounded and saturated.
// A word moves when valid and ready are both high at a rising edge of clk.
// Results come back in argument order. The path runs through the two logarithm units,
// each a chain of 56 squaring steps, and through the seven Horner stages of the series.
// One argument is taken every cycle unless the pipeline is held. The whole pipeline
// advances together: while a result waits in the output register and res.ready is low,
// every stage holds and arg.ready is low, so nothing is lost or repeated.
// rst_n clears all valid bits asynchronously; the block keeps no other state and is
// ready to take an argument in the first cycle after reset is released.
`default_nettype none

module dilogarithm_evaluator
    import dle_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    dle_x_if.sink    arg,
    dle_li2_if.source res
);

    localparam int T     = INT_BITS + FRAC_BITS;
    localparam int MW    = T + 1;
    localparam int S_RND = WORK_BITS - FRAC_BITS;

    localparam logic [MW-1:0]        ONE_IN     = MW'(1) << FRAC_BITS;
    localparam logic signed [MW-1:0] ONE_S      = ONE_IN;
    localparam logic signed [MW-1:0] NEG_ONE_S  = -ONE_S;
    localparam logic signed [MW-1:0] HALF_S     = ONE_S >>> 1;
    localparam logic signed [MW-1:0] TWO_S      = ONE_S <<< 1;
    localparam work_t                RND_ADD    = work_t'(64'd1 << (S_RND - 1));
    localparam work_t                MAX_OUT    = work_t'((64'd1 << (T - 1)) - 64'd1);
    localparam work_t                MIN_OUT    = -MAX_OUT - work_t'(64'd1);

    typedef struct packed {
        region_t region;
        work_t   z;
        work_t   u;
        work_t   z2;
        work_t   w;
        work_t   uu;
    } side_t;

    logic en;

    logic signed [MW-1:0] x_ext;
    logic [MW-1:0]        x_mag;
    logic [MW-1:0]        arg_a_next;
    logic [MW-1:0]        arg_b_next;
    region_t              region_next;

    logic          dec_vld_reg;
    logic [MW-1:0] dec_a_reg;
    logic [MW-1:0] dec_b_reg;
    region_t       dec_region_reg;

    logic    la_vld;
    logic    lb_vld;
    work_t   la;
    work_t   lb;
    region_t rd_reg [LOG_LAT];

    work_t   z_next;
    work_t   u_next;
    logic    s1_vld_reg;
    region_t s1_region_reg;
    work_t   s1_z_reg;
    work_t   s1_u_reg;

    logic    s2_vld_reg;
    region_t s2_region_reg;
    work_t   s2_z_reg;
    work_t   s2_u_reg;
    work_t   s2_zu_reg;

    logic  z2_vld;
    logic  w_vld;
    logic  uu_vld;
    work_t z2_m;
    work_t w_m;
    work_t uu_m;
    side_t m1d_reg [MUL_LAT];
    side_t m1_side_next;
    side_t ser_d_reg [SER_LAT];

    logic  p_vld;
    work_t p_out;
    side_t pre_side_next;
    work_t pm_next;
    logic  pre_vld_reg;
    side_t pre_side_reg;
    work_t pre_pm_reg;

    logic  zp_vld;
    work_t zp;
    side_t m3d_reg [MUL_LAT];

    work_t v_next;
    logic  c1_vld_reg;
    work_t c1_v_reg;

    logic [T-1:0] li2_next;
    logic         out_vld_reg;
    logic [T-1:0] out_li2_reg;

    assign en        = !out_vld_reg || res.ready;
    assign arg.ready = en;

    // Region decode and the two logarithm arguments.
    always_comb
    begin
        x_ext       = {arg.x_value[T-1], arg.x_value};
        x_mag       = x_ext[MW-1] ? MW'(-x_ext) : MW'(x_ext);
        arg_a_next  = ONE_IN;
        arg_b_next  = ONE_IN;
        region_next = REG_ONE;
        if (x_ext[MW-1])
        begin
            arg_a_next = ONE_IN + x_mag;
            if (x_ext > NEG_ONE_S)
            begin
                region_next = REG_NEG;
            end
            else
            begin
                region_next = REG_NEG_BIG;
                arg_b_next  = x_mag;
            end
        end
        else if (x_ext <= HALF_S)
        begin
            region_next = REG_LOW;
            arg_a_next  = ONE_IN - x_mag;
        end
        else if (x_ext < ONE_S)
        begin
            region_next = REG_MID;
            arg_a_next  = x_mag;
            arg_b_next  = ONE_IN - x_mag;
        end
        else if (x_ext == ONE_S)
        begin
            region_next = REG_ONE;
        end
        else if (x_ext <= TWO_S)
        begin
            region_next = REG_HIGH;
            arg_a_next  = x_mag;
            arg_b_next  = x_mag - ONE_IN;
        end
        else
        begin
            region_next = REG_BIG;
            arg_a_next  = x_mag;
            arg_b_next  = x_mag - ONE_IN;
        end
    end

    dle_log #(
        .MW (MW),
        .K  (FRAC_BITS)
    ) u_log_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (dec_vld_reg),
        .m       (dec_a_reg),
        .res_vld (la_vld),
        .lg      (la)
    );

    dle_log #(
        .MW (MW),
        .K  (FRAC_BITS)
    ) u_log_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (dec_vld_reg),
        .m       (dec_b_reg),
        .res_vld (lb_vld),
        .lg      (lb)
    );

    // Auxiliary z in [0, ln 2] and the correction logarithm u.
    always_comb
    begin
        z_next = '0;
        u_next = '0;
        case (rd_reg[LOG_LAT-1])
            REG_NEG_BIG:
            begin
                z_next = la - lb;
                u_next = -la;
            end
            REG_NEG:
            begin
                z_next = la;
            end
            REG_LOW:
            begin
                z_next = -la;
            end
            REG_MID:
            begin
                z_next = -la;
                u_next = lb;
            end
            REG_HIGH:
            begin
                z_next = la;
                u_next = lb - la;
            end
            REG_BIG:
            begin
                z_next = la - lb;
                u_next = la;
            end
            default:
            begin
                z_next = '0;
                u_next = '0;
            end
        endcase
    end

    dle_fmul u_mul_z2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (s2_vld_reg),
        .a_mag   (mag(s2_z_reg)),
        .b_mag   (mag(s2_z_reg)),
        .neg     (1'b0),
        .res_vld (z2_vld),
        .prod    (z2_m)
    );

    dle_fmul u_mul_w (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (s2_vld_reg),
        .a_mag   (mag(s2_u_reg)),
        .b_mag   (mag(s2_zu_reg)),
        .neg     (s2_u_reg[63] ^ s2_zu_reg[63]),
        .res_vld (w_vld),
        .prod    (w_m)
    );

    dle_fmul u_mul_uu (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (s2_vld_reg),
        .a_mag   (mag(s2_u_reg)),
        .b_mag   (mag(s2_u_reg)),
        .neg     (1'b0),
        .res_vld (uu_vld),
        .prod    (uu_m)
    );

    always_comb
    begin
        m1_side_next    = m1d_reg[MUL_LAT-1];
        m1_side_next.z2 = z2_m;
        m1_side_next.w  = w_m;
        m1_side_next.uu = uu_m;
    end

    dle_series u_series (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (z2_vld),
        .z2      (z2_m),
        .res_vld (p_vld),
        .poly    (p_out)
    );

    always_comb
    begin
        pre_side_next = ser_d_reg[SER_LAT-1];
        if (pre_side_next.region == REG_MID || pre_side_next.region == REG_HIGH)
        begin
            pm_next = p_out - pre_side_next.u;
        end
        else
        begin
            pm_next = p_out;
        end
    end

    dle_fmul u_mul_zp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld     (pre_vld_reg),
        .a_mag   (mag(pre_side_reg.z)),
        .b_mag   (mag(pre_pm_reg)),
        .neg     (pre_side_reg.z[63] ^ pre_pm_reg[63]),
        .res_vld (zp_vld),
        .prod    (zp)
    );

    // Reflection and inversion identities.
    always_comb
    begin
        side_t sd;
        work_t q;
        work_t h2;
        work_t uuh;
        sd  = m3d_reg[MUL_LAT-1];
        q   = shr_mag(sd.z2, 2);
        h2  = shr_mag(sd.z2, 1);
        uuh = shr_mag(sd.uu, 1);
        case (sd.region)
            REG_NEG_BIG: v_next = zp - q - sd.w - PI6;
            REG_NEG:     v_next = -zp - q;
            REG_LOW:     v_next = zp - q;
            REG_MID:     v_next = -zp + q + PI6;
            REG_HIGH:    v_next = zp - q - h2 + PI6;
            REG_BIG:     v_next = -zp + q - uuh + PI6 + PI6;
            default:     v_next = PI6;
        endcase
    end

    always_comb
    begin
        work_t rs;
        rs = (c1_v_reg + RND_ADD) >>> S_RND;
        if (rs > MAX_OUT)
        begin
            rs = MAX_OUT;
        end
        else if (rs < MIN_OUT)
        begin
            rs = MIN_OUT;
        end
        li2_next = rs[T-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_vld_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            pre_vld_reg <= 1'b0;
            c1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            dec_vld_reg <= arg.valid;
            s1_vld_reg  <= la_vld;
            s2_vld_reg  <= s1_vld_reg;
            pre_vld_reg <= p_vld;
            c1_vld_reg  <= zp_vld;
            out_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_a_reg      <= arg_a_next;
            dec_b_reg      <= arg_b_next;
            dec_region_reg <= region_next;

            rd_reg[0] <= dec_region_reg;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                rd_reg[i] <= rd_reg[i-1];
            end

            s1_region_reg <= rd_reg[LOG_LAT-1];
            s1_z_reg      <= z_next;
            s1_u_reg      <= u_next;

            s2_region_reg <= s1_region_reg;
            s2_z_reg      <= s1_z_reg;
            s2_u_reg      <= s1_u_reg;
            s2_zu_reg     <= s1_z_reg + shr_mag(s1_u_reg, 1);

            m1d_reg[0] <= '{region: s2_region_reg, z: s2_z_reg, u: s2_u_reg,
                            z2: '0, w: '0, uu: '0};
            for (int i = 1; i < MUL_LAT; i++)
            begin
                m1d_reg[i] <= m1d_reg[i-1];
            end

            ser_d_reg[0] <= m1_side_next;
            for (int i = 1; i < SER_LAT; i++)
            begin
                ser_d_reg[i] <= ser_d_reg[i-1];
            end

            pre_side_reg <= pre_side_next;
            pre_pm_reg   <= pm_next;

            m3d_reg[0] <= pre_side_reg;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                m3d_reg[i] <= m3d_reg[i-1];
            end

            c1_v_reg    <= v_next;
            out_li2_reg <= li2_next;
        end
    end

    assign res.valid     = out_vld_reg;
    assign res.li2_value = out_li2_reg;

    a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (la_vld == lb_vld) && (w_vld == z2_vld) && (uu_vld == z2_vld))
        else $error("Parallel units of one stage disagree on valid.");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |-> !arg.ready)
        else $error("Argument taken while the result register is blocked.");

    a_z_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> (!s1_z_reg[63] && (s1_z_reg < W_ONE)))
        else $error("Series variable outside its reduced range.");

endmodule

`default_nettype wire
